// ===== src/sdfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sdfe_pkg;

   typedef enum logic [2:0] {
      REQ_SONG   = 3'd0,
      REQ_VERSE  = 3'd1,
      REQ_LETTER = 3'd2,
      REQ_LED    = 3'd3,
      REQ_RAW    = 3'd4,
      REQ_SENSE  = 3'd5,
      REQ_STATUS = 3'd6
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_MIDI   = 2'd0,
      KIND_FRAME  = 2'd1,
      KIND_STATUS = 2'd2
   } out_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_UPDATE,
      ST_EMIT,
      ST_STATUS
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic split;
      logic update;
      logic advance;
      logic show_status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic send;
      logic final_step;
   } dp_status_type;

   localparam int FRAME_LEN = 9;
   localparam int FRAME_IDX_W = 4;

   localparam logic [7:0] FRAME_RESET [FRAME_LEN] = '{
      8'hB0, 8'hE0, 8'hE0, 8'hE0, 8'hE0, 8'hE0, 8'hE0, 8'h0E, 8'hE0
   };

   localparam logic [10:0] SONG_MAX    = 11'd1999;
   localparam logic [6:0]  VERSE_MAX   = 7'd99;
   localparam logic [7:0]  BLANK       = 8'hE0;
   localparam logic [7:0]  LETTER_BASE = 8'd55;
   localparam logic [7:0]  LETTER_A    = 8'd65;
   localparam logic [7:0]  LETTER_D    = 8'd68;

   localparam logic [7:0] CIN_SYSEX_CONT = 8'h04;
   localparam logic [7:0] CIN_SYSEX_END2 = 8'h06;
   localparam logic [7:0] SYSEX_START    = 8'hF0;
   localparam logic [7:0] SYSEX_ID0      = 8'h4D;
   localparam logic [7:0] SYSEX_ID1      = 8'h43;
   localparam logic [7:0] SYSEX_END      = 8'hF7;
   localparam logic [7:0] SYSEX_CMD      = 8'h01;
   localparam logic [7:0] CODE_NONE      = 8'h0F;

   localparam logic [3:0] STEP_HEAD   = 4'd0;
   localparam logic [3:0] STEP_SONG_H = 4'd1;
   localparam logic [3:0] STEP_SONG_L = 4'd2;
   localparam logic [3:0] STEP_VERSE  = 4'd3;
   localparam logic [3:0] STEP_LED    = 4'd4;
   localparam logic [3:0] STEP_FRAME0 = 4'd5;
   localparam logic [3:0] STEP_LAST   = 4'd13;

endpackage
`default_nettype wire

// ===== src/sdfe_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sdfe_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [15:0] value;
   logic        visible;
   logic [7:0]  byte_index;
   logic        sense_level;

   modport source (
      output valid, req_type, value, visible, byte_index, sense_level,
      input  ready
   );
   modport sink (
      input  valid, req_type, value, visible, byte_index, sense_level,
      output ready
   );
endinterface
`default_nettype wire

// ===== src/sdfe_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sdfe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [31:0] out_data;
   logic        out_last;
   logic [14:0] song_now;
   logic [7:0]  verse_now;
   logic [6:0]  letter_now;
   logic [7:0]  led_now;
   logic        is_connected;
   logic        was_changed;

   modport source (
      output valid, out_kind, out_data, out_last, song_now, verse_now, letter_now,
             led_now, is_connected, was_changed,
      input  ready
   );
   modport sink (
      input  valid, out_kind, out_data, out_last, song_now, verse_now, letter_now,
             led_now, is_connected, was_changed,
      output ready
   );
endinterface
`default_nettype wire

// ===== src/sdfe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sdfe_ctrl
   import sdfe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = status.send ? ST_EMIT : ST_STATUS;
         end
         ST_EMIT: begin
            if (rsp_ready && status.final_step) begin
               state_in = ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         ST_STATUS: begin
            rsp_valid       = 1'b1;
            cmd.show_status = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/sdfe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sdfe_datapath
   import sdfe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   input  wire logic [2:0]    req_type,
   input  wire logic [15:0]   value,
   input  wire logic          visible,
   input  wire logic [7:0]    byte_index,
   input  wire logic          sense_level,
   output logic [1:0]         out_kind,
   output logic [31:0]        out_data,
   output logic               out_last,
   output logic [14:0]        song_now,
   output logic [7:0]         verse_now,
   output logic [6:0]         letter_now,
   output logic [7:0]         led_now,
   output logic               is_connected,
   output logic               was_changed
);

   function automatic logic [7:0] digit_code(input logic [7:0] b);
      return (b[7:4] == 4'hE) ? CODE_NONE : {4'h0, b[3:0]};
   endfunction

   function automatic logic [7:0] letter_code(input logic [7:0] b);
      return (b[3:0] >= 4'hA && b[3:0] <= 4'hD) ? {4'h0, b[3:0]} : CODE_NONE;
   endfunction

   function automatic logic [7:0] led_code(input logic [7:0] b);
      logic [7:0] c;
      case (b)
         8'd0:    c = 8'h01;
         8'd1:    c = 8'h04;
         8'd2:    c = 8'h02;
         8'd3:    c = 8'h03;
         default: c = CODE_NONE;
      endcase
      return c;
   endfunction

   // captured transaction
   logic [2:0]  type_ff;
   logic [15:0] value_ff;
   logic        vis_ff;
   logic [7:0]  idx_ff;
   logic        sense_ff;

   // decimal split results
   logic        thou_ff, thou_in;
   logic [3:0]  hund_ff, hund_in;
   logic [6:0]  rem_ff, rem_in;

   logic [7:0]  frame_ff [FRAME_LEN];
   logic [7:0]  frame_in [FRAME_LEN];
   logic        link_ff, link_in;
   logic        dirty_ff, dirty_in;
   logic [3:0]  step_ff, step_in;

   logic [10:0] song_clamp;
   logic [9:0]  song_rem;
   logic [15:0] hund_prod;
   logic [9:0]  hund_sub;
   logic [6:0]  verse_clamp;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic [7:0]  letter_byte;
   logic        send_cmd;
   logic [FRAME_IDX_W-1:0] frame_idx;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         value_ff <= value;
         vis_ff   <= visible;
         idx_ff   <= byte_index;
         sense_ff <= sense_level;
      end
      thou_ff <= thou_in;
      hund_ff <= hund_in;
      rem_ff  <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FRAME_RESET;
         link_ff  <= 1'b0;
         dirty_ff <= 1'b1;
         step_ff  <= 4'd0;
      end else begin
         frame_ff <= frame_in;
         link_ff  <= link_in;
         dirty_ff <= dirty_in;
         step_ff  <= step_in;
      end
   end

   // first split step: thousands and hundreds, or the clamped verse
   always_comb begin
      song_clamp  = (value_ff > 16'(SONG_MAX)) ? SONG_MAX : value_ff[10:0];
      verse_clamp = (value_ff > 16'(VERSE_MAX)) ? VERSE_MAX : value_ff[6:0];
      thou_in     = thou_ff;
      hund_in     = hund_ff;
      rem_in      = rem_ff;
      song_rem    = (song_clamp >= 11'd1000) ? 10'(song_clamp - 11'd1000) : song_clamp[9:0];
      // r * 41 / 4096 equals r / 100 for r below 1000
      hund_prod   = 16'(song_rem) * 16'd41;
      hund_sub    = 10'(hund_prod[15:12]) * 10'd100;
      if (cmd.split) begin
         thou_in = (song_clamp >= 11'd1000);
         hund_in = hund_prod[15:12];
         rem_in  = (type_ff == REQ_SONG) ? 7'(song_rem - hund_sub) : verse_clamp;
      end
   end

   always_comb begin
      case (type_ff)
         REQ_SONG, REQ_VERSE, REQ_LETTER, REQ_LED: send_cmd = 1'b1;
         default:                                  send_cmd = 1'b0;
      endcase
   end

   // second split step and frame update
   always_comb begin
      // r * 205 / 2048 equals r / 10 for r below 100
      tens_prod   = 15'(rem_ff) * 15'd205;
      tens        = tens_prod[14:11];
      ones        = 4'(rem_ff - 7'(7'(tens) * 7'd10));
      letter_byte = (value_ff < 16'(LETTER_A) || value_ff > 16'(LETTER_D)) ? 8'd10
                  : 8'(value_ff[7:0] - LETTER_BASE);
      frame_in    = frame_ff;
      link_in     = link_ff;
      dirty_in    = dirty_ff;
      if (cmd.update) begin
         case (type_ff)
            REQ_SONG: begin
               frame_in[3] = vis_ff ? {4'h0, ones} : BLANK;
               frame_in[4] = vis_ff ? {4'h0, tens} : BLANK;
               frame_in[5] = vis_ff ? {4'h0, hund_ff} : BLANK;
               frame_in[6] = vis_ff ? {7'h00, thou_ff} : BLANK;
            end
            REQ_VERSE: begin
               frame_in[1] = vis_ff ? {4'h0, ones} : BLANK;
               frame_in[2] = vis_ff ? {4'h0, tens} : BLANK;
            end
            REQ_LETTER: begin
               frame_in[7] = vis_ff ? letter_byte : BLANK;
            end
            REQ_LED: begin
               frame_in[8] = value_ff[7:0];
            end
            REQ_RAW: begin
               if (idx_ff < 8'(FRAME_LEN)) begin
                  frame_in[idx_ff[FRAME_IDX_W-1:0]] = value_ff[7:0];
                  dirty_in = 1'b1;
               end
            end
            REQ_SENSE: begin
               link_in = ~sense_ff;
            end
            default: begin
               link_in = link_ff;
            end
         endcase
         // link is untouched by sending commands, so the old flag decides
         if (send_cmd && link_ff) begin
            dirty_in = 1'b0;
         end
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.update) begin
         step_in = 4'd0;
      end else if (cmd.advance) begin
         step_in = 4'(step_ff + 4'd1);
      end
   end

   assign status.send       = send_cmd && link_ff;
   assign status.final_step = (step_ff == STEP_LAST);

   // result payload
   always_comb begin
      frame_idx = FRAME_IDX_W'(step_ff - STEP_FRAME0);
      out_kind  = KIND_MIDI;
      out_data  = 32'd0;
      out_last  = 1'b0;
      if (cmd.show_status) begin
         out_kind = KIND_STATUS;
         out_last = 1'b1;
      end else begin
         case (step_ff)
            STEP_HEAD: begin
               out_data = {CIN_SYSEX_CONT, SYSEX_START, SYSEX_ID0, SYSEX_ID1};
            end
            STEP_SONG_H: begin
               out_data = {CIN_SYSEX_CONT, SYSEX_CMD, 8'h00, digit_code(frame_ff[6])};
            end
            STEP_SONG_L: begin
               out_data = {CIN_SYSEX_CONT, digit_code(frame_ff[5]),
                           digit_code(frame_ff[4]), digit_code(frame_ff[3])};
            end
            STEP_VERSE: begin
               out_data = {CIN_SYSEX_CONT, digit_code(frame_ff[2]),
                           digit_code(frame_ff[1]), letter_code(frame_ff[7])};
            end
            STEP_LED: begin
               out_data = {CIN_SYSEX_END2, led_code(frame_ff[8]), SYSEX_END, 8'h00};
            end
            default: begin
               if (step_ff >= STEP_FRAME0 && step_ff <= STEP_LAST) begin
                  out_kind = KIND_FRAME;
                  out_data = {24'h000000, frame_ff[frame_idx]};
                  out_last = (step_ff == STEP_LAST);
               end
            end
         endcase
      end
   end

   assign song_now   = 15'(frame_ff[3][3:0])
                     + 15'(frame_ff[4][3:0]) * 15'd10
                     + 15'(frame_ff[5][3:0]) * 15'd100
                     + 15'(frame_ff[6][3:0]) * 15'd1000;
   assign verse_now  = 8'(frame_ff[1][3:0]) + 8'(frame_ff[2][3:0]) * 8'd10;
   assign letter_now = 7'(frame_ff[7][3:0]) + 7'(LETTER_BASE);
   assign led_now    = frame_ff[8];
   assign is_connected = link_ff;
   assign was_changed  = dirty_ff;

endmodule
`default_nettype wire

// ===== src/segment_display_frame_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Segment display frame encoder.
// req: one command per transaction (song, verse, letter, LED, raw byte write,
//   sense event, status query). req.ready is high only while the block is idle.
// rsp: the results of a command, the last one flagged by out_last. A song,
//   verse, letter or LED command with the display connected yields five SysEx
//   packets and then the nine frame bytes (14 transactions); every other case
//   yields one status-only transaction. All status fields show the state after
//   the command.
// The first result becomes valid once the accepted command has gone through
//   capture, decimal split and frame update in the controller sequence.
// The controller walks through the results one per cycle while rsp.ready is
//   high; the block takes no new command until the last result is taken.
// Reset: the frame returns to its blank pattern, the link flag clears and the
//   changed flag sets.
// Stall: while rsp.ready is low the current result holds and nothing advances.
module segment_display_frame_encoder
   import sdfe_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sdfe_req_if.sink    req,
   sdfe_rsp_if.source  rsp
);

   dp_cmd_type    cmd;
   dp_status_type status;

   sdfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sdfe_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_type     (req.req_type),
      .value        (req.value),
      .visible      (req.visible),
      .byte_index   (req.byte_index),
      .sense_level  (req.sense_level),
      .out_kind     (rsp.out_kind),
      .out_data     (rsp.out_data),
      .out_last     (rsp.out_last),
      .song_now     (rsp.song_now),
      .verse_now    (rsp.verse_now),
      .letter_now   (rsp.letter_now),
      .led_now      (rsp.led_now),
      .is_connected (rsp.is_connected),
      .was_changed  (rsp.was_changed)
   );

   // busy from acceptance until the last result is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("command accepted while a transaction is in flight");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.out_last |=> req.ready && !rsp.valid)
      else $error("block not idle after last result");

   a_frame_needs_link: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.out_kind == KIND_FRAME || rsp.out_kind == KIND_MIDI)
      |-> rsp.is_connected && !rsp.was_changed)
      else $error("frame sent without link or with changed flag set");

   a_packet_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.out_kind == KIND_MIDI |-> !rsp.out_last)
      else $error("packet flagged as last result");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench
   import sdfe_pkg::*;
();

   localparam logic [2:0] REQ_UNUSED = 3'd7;
   localparam logic [7:0] LED_RED    = 8'd0;
   localparam logic [7:0] LED_YELLOW = 8'd1;
   localparam logic [7:0] LED_GREEN  = 8'd2;
   localparam logic [7:0] LED_BLUE   = 8'd3;

   localparam int N_DIRECTED      = 25;
   localparam int N_RANDOM        = 200;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic        visible;
      logic [7:0]  index;
      logic        sense;
   } command_type;

   typedef struct packed {
      out_kind_type kind;
      logic [31:0]  data;
      logic         last;
      logic [14:0]  song;
      logic [7:0]   verse;
      logic [6:0]   letter;
      logic [7:0]   led;
      logic         linked;
      logic         changed;
   } result_type;

   typedef struct packed {
      command_type cmd;
      logic        typed;
      result_type  res;
   } step_row_type;

   // status-only results that follow straight from the reset frame
   localparam result_type NO_TYPED = '0;
   localparam result_type AFTER_RESET =
      '{KIND_STATUS, 32'd0, 1'b1, 15'd0, 8'd0, 7'd69, 8'hE0, 1'b0, 1'b1};
   localparam result_type SONG_MAX_UNLINKED =
      '{KIND_STATUS, 32'd0, 1'b1, 15'd1999, 8'd0, 7'd69, 8'hE0, 1'b0, 1'b1};
   localparam result_type SONG_MAX_LINKED =
      '{KIND_STATUS, 32'd0, 1'b1, 15'd1999, 8'd0, 7'd69, 8'hE0, 1'b1, 1'b1};

   localparam step_row_type DIRECTED_STEPS [N_DIRECTED] = '{
      '{'{REQ_STATUS, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b1, AFTER_RESET},
      '{'{REQ_SONG,   16'hFFFF, 1'b1, 8'h00, 1'b0}, 1'b1, SONG_MAX_UNLINKED},
      '{'{REQ_RAW,    16'hFFFF, 1'b0, 8'hFF, 1'b0}, 1'b1, SONG_MAX_UNLINKED},
      '{'{REQ_RAW,    16'h0055, 1'b1, 8'h09, 1'b1}, 1'b1, SONG_MAX_UNLINKED},
      '{'{REQ_UNUSED, 16'hFFFF, 1'b1, 8'hFF, 1'b1}, 1'b1, SONG_MAX_UNLINKED},
      '{'{REQ_SENSE,  16'h0000, 1'b0, 8'h00, 1'b1}, 1'b1, SONG_MAX_UNLINKED},
      '{'{REQ_SENSE,  16'h0000, 1'b0, 8'h00, 1'b0}, 1'b1, SONG_MAX_LINKED},
      '{'{REQ_SONG,   16'h0000, 1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_SONG,   16'd2000, 1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_SONG,   16'd1234, 1'b0, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_VERSE,  16'd99,   1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_VERSE,  16'hFFFF, 1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_VERSE,  16'd7,    1'b0, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LETTER, 16'd64,   1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LETTER, 16'd68,   1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LETTER, 16'd69,   1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LETTER, 16'd66,   1'b0, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LED,    16'(LED_RED),    1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LED,    16'(LED_YELLOW), 1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LED,    16'(LED_BLUE),   1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LED,    16'h0080, 1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_RAW,    16'h1203, 1'b0, 8'h08, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_RAW,    16'h0009, 1'b0, 8'h07, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_RAW,    16'h00A5, 1'b0, 8'h03, 1'b0}, 1'b0, NO_TYPED},
      '{'{REQ_LED,    16'hFF00 | 16'(LED_GREEN), 1'b1, 8'h00, 1'b0}, 1'b0, NO_TYPED}
   };

   logic clock;
   logic reset;

   sdfe_req_if req ();
   sdfe_rsp_if rsp ();

   segment_display_frame_encoder uut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   logic [7:0] shadow_frame [FRAME_LEN];
   logic       shadow_link;
   logic       shadow_changed;
   result_type due_results [$];
   int         mismatches;
   bit         steady;
   bit         hold_request;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[segment_display_frame_encoder] ERROR");
      $finish;
   end

   function automatic logic [7:0] digit_sym(logic [7:0] b);
      return (b[7:4] == 4'hE) ? CODE_NONE : {4'h0, b[3:0]};
   endfunction

   function automatic logic [7:0] letter_sym(logic [7:0] b);
      return (b[3:0] >= 4'd10 && b[3:0] <= 4'd13) ? {4'h0, b[3:0]} : CODE_NONE;
   endfunction

   function automatic logic [7:0] led_sym(logic [7:0] b);
      case (b)
         LED_RED:    return 8'h01;
         LED_YELLOW: return 8'h04;
         LED_GREEN:  return 8'h02;
         LED_BLUE:   return 8'h03;
         default:    return CODE_NONE;
      endcase
   endfunction

   function automatic string describe(result_type r);
      return $sformatf({"kind %0d data %h last %0d song %0d verse %0d letter %0d",
                        " led %h link %0d chg %0d"},
                       r.kind, r.data, r.last, r.song, r.verse, r.letter, r.led, r.linked,
                       r.changed);
   endfunction

   // update the shadow frame for one command and queue the results it yields
   function automatic void apply_command(command_type c);
      logic        send;
      int          s;
      logic [15:0] l;
      result_type  r;
      send = 1'b0;
      case (c.kind)
         REQ_SONG: begin
            if (c.visible) begin
               s = (c.value > 16'(SONG_MAX)) ? int'(SONG_MAX) : int'(c.value);
               shadow_frame[3] = 8'(s % 10);
               shadow_frame[4] = 8'(s / 10 % 10);
               shadow_frame[5] = 8'(s / 100 % 10);
               shadow_frame[6] = 8'((s / 1000) & 15);
            end else begin
               for (int i = 3; i <= 6; i++) shadow_frame[i] = BLANK;
            end
            send = 1'b1;
         end
         REQ_VERSE: begin
            if (c.visible) begin
               s = (c.value > 16'(VERSE_MAX)) ? int'(VERSE_MAX) : int'(c.value);
               shadow_frame[1] = 8'(s % 10);
               shadow_frame[2] = 8'(s / 10);
            end else begin
               shadow_frame[1] = BLANK;
               shadow_frame[2] = BLANK;
            end
            send = 1'b1;
         end
         REQ_LETTER: begin
            if (c.visible) begin
               l = (c.value < 16'(LETTER_A) || c.value > 16'(LETTER_D)) ?
                   16'(LETTER_A) : c.value;
               shadow_frame[7] = 8'((l - 16'(LETTER_BASE)) & 16'h000F);
            end else begin
               shadow_frame[7] = BLANK;
            end
            send = 1'b1;
         end
         REQ_LED: begin
            shadow_frame[8] = c.value[7:0];
            send = 1'b1;
         end
         REQ_RAW: begin
            if (c.index < 8'(FRAME_LEN)) begin
               shadow_frame[c.index[3:0]] = c.value[7:0];
               shadow_changed = 1'b1;
            end
         end
         REQ_SENSE: shadow_link = ~c.sense;
         default: ;
      endcase

      send = send & shadow_link;
      if (send) shadow_changed = 1'b0;

      r.song = 15'(int'(shadow_frame[3][3:0]) + 10 * int'(shadow_frame[4][3:0])
                  + 100 * int'(shadow_frame[5][3:0]) + 1000 * int'(shadow_frame[6][3:0]));
      r.verse   = 8'(int'(shadow_frame[1][3:0]) + 10 * int'(shadow_frame[2][3:0]));
      r.letter  = 7'({4'h0, shadow_frame[7][3:0]} + LETTER_BASE);
      r.led     = shadow_frame[8];
      r.linked  = shadow_link;
      r.changed = shadow_changed;

      if (!send) begin
         r.kind = KIND_STATUS;
         r.data = 32'd0;
         r.last = 1'b1;
         due_results.push_back(r);
         return;
      end

      r.kind = KIND_MIDI;
      r.last = 1'b0;
      r.data = {CIN_SYSEX_CONT, SYSEX_START, SYSEX_ID0, SYSEX_ID1};
      due_results.push_back(r);
      r.data = {CIN_SYSEX_CONT, SYSEX_CMD, 8'h00, digit_sym(shadow_frame[6])};
      due_results.push_back(r);
      r.data = {CIN_SYSEX_CONT, digit_sym(shadow_frame[5]), digit_sym(shadow_frame[4]),
                digit_sym(shadow_frame[3])};
      due_results.push_back(r);
      r.data = {CIN_SYSEX_CONT, digit_sym(shadow_frame[2]), digit_sym(shadow_frame[1]),
                letter_sym(shadow_frame[7])};
      due_results.push_back(r);
      r.data = {CIN_SYSEX_END2, led_sym(shadow_frame[8]), SYSEX_END, 8'h00};
      due_results.push_back(r);
      r.kind = KIND_FRAME;
      for (int i = 0; i < FRAME_LEN; i++) begin
         r.data = {24'h0, shadow_frame[i]};
         r.last = (i == FRAME_LEN - 1);
         due_results.push_back(r);
      end
   endfunction

   function automatic command_type random_command();
      command_type c;
      int          pick;
      c.value   = 16'($urandom_range(16'hFFFF));
      c.visible = ($urandom_range(9) != 0);
      c.index   = 8'($urandom_range(255));
      c.sense   = 1'($urandom_range(1));
      pick      = $urandom_range(99);
      if (pick < 8) begin
         c.kind  = REQ_SENSE;
         c.sense = ($urandom_range(3) == 0);
      end else if (pick < 15) begin
         c.kind = REQ_RAW;
         if ($urandom_range(3) != 0) c.index = 8'($urandom_range(FRAME_LEN - 1));
      end else if (pick < 20) begin
         c.kind = $urandom_range(1) ? REQ_STATUS : REQ_UNUSED;
      end else begin
         case ($urandom_range(3))
            0: begin
               c.kind = REQ_SONG;
               case ($urandom_range(3))
                  0, 1: c.value = 16'($urandom_range(SONG_MAX));
                  2:    c.value = 16'($urandom_range(2010, 1990));
                  default: ;
               endcase
            end
            1: begin
               c.kind = REQ_VERSE;
               case ($urandom_range(3))
                  0, 1: c.value = 16'($urandom_range(VERSE_MAX));
                  2:    c.value = 16'($urandom_range(110, 95));
                  default: ;
               endcase
            end
            2: begin
               c.kind = REQ_LETTER;
               if ($urandom_range(3) != 0) c.value = 16'($urandom_range(70, 62));
            end
            default: begin
               c.kind = REQ_LED;
               if ($urandom_range(3) != 0) c.value = 16'($urandom_range(4));
            end
         endcase
      end
      return c;
   endfunction

   // hold the transaction until the block takes it, then queue its results
   task automatic offer(input command_type c, input logic typed, input result_type typed_res);
      while (!steady && $urandom_range(99) < 18) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.req_type    <= c.kind;
      req.value       <= c.value;
      req.visible     <= c.visible;
      req.byte_index  <= c.index;
      req.sense_level <= c.sense;
      do @(posedge clock); while (!req.ready);
      apply_command(c);
      if (typed) begin
         void'(due_results.pop_back());
         due_results.push_back(typed_res);
      end
   endtask

   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp.ready <= steady || ($urandom_range(99) >= 18);
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind    = out_kind_type'(rsp.out_kind);
         got.data    = rsp.out_data;
         got.last    = rsp.out_last;
         got.song    = rsp.song_now;
         got.verse   = rsp.verse_now;
         got.letter  = rsp.letter_now;
         got.led     = rsp.led_now;
         got.linked  = rsp.is_connected;
         got.changed = rsp.was_changed;
         if (due_results.size() == 0) begin
            if (mismatches < 10) $display("unexpected result: %s", describe(got));
            mismatches++;
         end else begin
            want = due_results.pop_front();
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("mismatch expected: %s", describe(want));
                  $display("         actual:   %s", describe(got));
               end
               mismatches++;
            end
         end
      end
   end

   initial begin
      command_type c;
      mismatches     = 0;
      steady         = 1'b0;
      hold_request   = 1'b0;
      shadow_link    = 1'b0;
      shadow_changed = 1'b1;
      for (int i = 0; i < FRAME_LEN; i++) shadow_frame[i] = FRAME_RESET[i];

      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.req_type    <= REQ_STATUS;
      req.value       <= '0;
      req.visible     <= 1'b0;
      req.byte_index  <= '0;
      req.sense_level <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_STEPS[i])
         offer(DIRECTED_STEPS[i].cmd, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].res);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 40) hold_request = 1'b1;
         if (n == 80) steady = 1'b1;
         if (n == 120) steady = 1'b0;
         if (n == 150) begin
            // drain the block completely before going on
            req.valid <= 1'b0;
            while (due_results.size() != 0) @(posedge clock);
         end
         c = random_command();
         offer(c, 1'b0, NO_TYPED);
      end
      req.valid <= 1'b0;

      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("[segment_display_frame_encoder] OK");
      else
         $display("[segment_display_frame_encoder] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sdfe_pkg.sv
src/sdfe_req_if.sv
src/sdfe_rsp_if.sv
src/sdfe_ctrl.sv
src/sdfe_datapath.sv
src/segment_display_frame_encoder.sv
tb/sv/testbench.sv
